>>> design/rgbhsv_pkg.sv
package rgbhsv_pkg;

  // Channel and arithmetic widths.
  localparam int unsigned PixW  = 8;
  localparam int unsigned QuotW = PixW + 1;
  localparam int unsigned HueW  = 12;

  // One divider cell per quotient bit of the two divisions.
  localparam int unsigned NumCells = QuotW;

  // Configuration register map.
  localparam int unsigned PaddrW     = 3;
  localparam logic        RegSatThr  = 1'b0;
  localparam logic [PixW-1:0] SatThrReset = 8'd50;

  // Hue sector bases and full circle in 1/256 units of a sector.
  localparam logic [10:0]       SectorGreenBase = 11'd512;
  localparam logic [10:0]       SectorBlueBase  = 11'd1024;
  localparam logic signed [HueW-1:0] FullCircle = 12'sd1536;

  // Reciprocal of six: (h * 10923) >> 16 is exact for h below 1536.
  localparam logic [13:0] RecipSix = 14'd10923;

  typedef enum logic [1:0] {
    SECTOR_RED   = 2'b00,
    SECTOR_GREEN = 2'b01,
    SECTOR_BLUE  = 2'b10
  } sector_e;

  // Item carried along the pipeline from the front stage through the cells.
  typedef struct packed {
    logic [PixW-1:0]  vmax;
    logic [PixW-1:0]  delta;
    logic             sat_en;
    sector_e          sector;
    logic             neg;
    logic [PixW-1:0]  rem_s;
    logic             lo_s;
    logic [QuotW-1:0] quot_s;
    logic [PixW-1:0]  rem_h;
    logic             lo_h;
    logic [QuotW-1:0] quot_h;
  } item_t;

endpackage

>>> design/rgbhsv_front.sv
module rgbhsv_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [rgbhsv_pkg::PixW-1:0] red_i,
  input  logic [rgbhsv_pkg::PixW-1:0] green_i,
  input  logic [rgbhsv_pkg::PixW-1:0] blue_i,
  input  logic [rgbhsv_pkg::PixW-1:0] thr_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output rgbhsv_pkg::item_t        item_o
);
  import rgbhsv_pkg::*;

  logic [PixW-1:0]   vmax;
  logic [PixW-1:0]   vmin;
  logic [PixW-1:0]   delta;
  logic signed [PixW:0] diff;
  logic [PixW-1:0]   adiff;
  item_t             item_d;
  item_t             item_q;
  logic              valid_q;

  // Largest and smallest channel.
  always_comb begin
    vmax = (red_i > green_i) ? red_i : green_i;
    vmax = (vmax > blue_i) ? vmax : blue_i;
    vmin = (red_i < green_i) ? red_i : green_i;
    vmin = (vmin < blue_i) ? vmin : blue_i;
    delta = vmax - vmin;
  end

  // Sector choice, red first, then green, then blue; signed channel difference.
  always_comb begin
    item_d = '0;
    if (red_i == vmax) begin
      item_d.sector = SECTOR_RED;
      diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == vmax) begin
      item_d.sector = SECTOR_GREEN;
      diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      item_d.sector = SECTOR_BLUE;
      diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    adiff = diff[PixW] ? PixW'(-diff) : diff[PixW-1:0];

    item_d.vmax   = vmax;
    item_d.delta  = delta;
    item_d.sat_en = (vmax > thr_i);
    item_d.neg    = diff[PixW];
    // The upper bits seed the partial remainder; the lowest bit enters the first cell.
    item_d.rem_s  = {1'b0, delta[PixW-1:1]};
    item_d.lo_s   = delta[0];
    item_d.rem_h  = {1'b0, adiff[PixW-1:1]};
    item_d.lo_h   = adiff[0];
  end

  // Stage handshake: hold while a stored item is blocked downstream.
  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/rgbhsv_div_cell.sv
module rgbhsv_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  rgbhsv_pkg::item_t item_i,
  output logic              valid_o,
  input  logic              stall_i,
  output rgbhsv_pkg::item_t item_o
);
  import rgbhsv_pkg::*;

  logic [PixW:0] trial_s;
  logic [PixW:0] trial_h;
  logic [PixW:0] diff_s;
  logic [PixW:0] diff_h;
  logic          ge_s;
  logic          ge_h;
  item_t         item_d;
  item_t         item_q;
  logic          valid_q;

  // One restoring step for each division: saturation over value, hue over chroma.
  always_comb begin
    trial_s = {item_i.rem_s, item_i.lo_s};
    trial_h = {item_i.rem_h, item_i.lo_h};
    diff_s  = trial_s - {1'b0, item_i.vmax};
    diff_h  = trial_h - {1'b0, item_i.delta};
    ge_s    = (trial_s >= {1'b0, item_i.vmax});
    ge_h    = (trial_h >= {1'b0, item_i.delta});

    item_d        = item_i;
    item_d.rem_s  = ge_s ? diff_s[PixW-1:0] : trial_s[PixW-1:0];
    item_d.rem_h  = ge_h ? diff_h[PixW-1:0] : trial_h[PixW-1:0];
    item_d.quot_s = {item_i.quot_s[QuotW-2:0], ge_s};
    item_d.quot_h = {item_i.quot_h[QuotW-2:0], ge_h};
    // Only zeros follow the first numerator bit.
    item_d.lo_s   = 1'b0;
    item_d.lo_h   = 1'b0;
  end

  // Stage handshake.
  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> design/rgbhsv_back.sv
module rgbhsv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  rgbhsv_pkg::item_t           item_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [rgbhsv_pkg::PixW-1:0] hue_o,
  output logic [rgbhsv_pkg::PixW-1:0] saturation_o,
  output logic [rgbhsv_pkg::PixW-1:0] value_o,
  output logic [rgbhsv_pkg::PixW-1:0] chroma_o
);
  import rgbhsv_pkg::*;

  logic [10:0]          base;
  logic signed [HueW-1:0] hue_s;
  logic signed [HueW-1:0] hue_w;
  logic [24:0]          prod;
  logic                 grey;
  logic [PixW-1:0]      hue_d;
  logic [PixW-1:0]      sat_d;
  logic [PixW-1:0]      chroma_d;
  logic [PixW-1:0]      hue_q;
  logic [PixW-1:0]      sat_q;
  logic [PixW-1:0]      value_q;
  logic [PixW-1:0]      chroma_q;
  logic                 valid_q;

  // Sector base plus the signed quotient, wrapped into one circle, then divided by six.
  always_comb begin
    case (item_i.sector)
      SECTOR_RED:   base = 11'd0;
      SECTOR_GREEN: base = SectorGreenBase;
      SECTOR_BLUE:  base = SectorBlueBase;
      default:      base = 11'd0;
    endcase
    if (item_i.neg) begin
      hue_s = $signed({1'b0, base}) - $signed({3'b000, item_i.quot_h});
    end else begin
      hue_s = $signed({1'b0, base}) + $signed({3'b000, item_i.quot_h});
    end
    hue_w = hue_s[HueW-1] ? (hue_s + FullCircle) : hue_s;
    prod  = hue_w[10:0] * RecipSix;
  end

  // Grey pixels give zero hue, saturation and chroma; saturation clips at 255.
  always_comb begin
    grey     = (item_i.delta == '0);
    hue_d    = grey ? '0 : prod[23:16];
    chroma_d = item_i.delta;
    if (grey || !item_i.sat_en) begin
      sat_d = '0;
    end else if (item_i.quot_s[QuotW-1]) begin
      sat_d = '1;
    end else begin
      sat_d = item_i.quot_s[PixW-1:0];
    end
  end

  // Output register; holds its transfer while the consumer stalls.
  assign stall_o = valid_q & stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      value_q  <= item_i.vmax;
      chroma_q <= chroma_d;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;
  assign chroma_o     = chroma_q;

endmodule

>>> design/rgb_to_hsv_chroma.sv
// Channel   | Signals                                         | Direction
// ----------+-------------------------------------------------+----------
// pixel in  | in_valid_i, in_stall_o, red_i, green_i, blue_i  | input
// hsv out   | out_valid_o, out_stall_i, hue_o, saturation_o,  | output
//           | value_o, chroma_o                               |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,   | APB slave
//           | pready                                          |
//
// One pixel is taken per clock while in_stall_o is low. A pixel reaches the output register
// after its input transfer, having passed one front stage, nine divider cells (one quotient
// bit each) and the output stage, each of them a register.
// Reset clears all stage valid bits and loads the threshold with 50.
// A stall at the output holds only the stages that hold data; empty stages keep filling.
module rgb_to_hsv_chroma (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rgbhsv_pkg::PixW-1:0]   red_i,
  input  logic [rgbhsv_pkg::PixW-1:0]   green_i,
  input  logic [rgbhsv_pkg::PixW-1:0]   blue_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rgbhsv_pkg::PixW-1:0]   hue_o,
  output logic [rgbhsv_pkg::PixW-1:0]   saturation_o,
  output logic [rgbhsv_pkg::PixW-1:0]   value_o,
  output logic [rgbhsv_pkg::PixW-1:0]   chroma_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgbhsv_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rgbhsv_pkg::*;

  logic [PixW-1:0] thr_q;
  logic            sel_thr;

  logic  valid_c [0:NumCells];
  logic  stall_c [0:NumCells];
  item_t item_c  [0:NumCells];

  // Configuration register.
  assign pready  = 1'b1;
  assign sel_thr = (paddr[PaddrW-1] == RegSatThr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= SatThrReset;
    end else if (psel && penable && pwrite && pready && sel_thr) begin
      thr_q <= pwdata[PixW-1:0];
    end
  end

  assign prdata = sel_thr ? {{(32 - PixW){1'b0}}, thr_q} : '0;

  // Front stage: max, min, sector and divider seeds.
  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .thr_i   (thr_q),
    .valid_o (valid_c[0]),
    .stall_i (stall_c[0]),
    .item_o  (item_c[0])
  );

  // Row of divider cells, one quotient bit per cell.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rgbhsv_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .stall_o (stall_c[k]),
      .item_i  (item_c[k]),
      .valid_o (valid_c[k+1]),
      .stall_i (stall_c[k+1]),
      .item_o  (item_c[k+1])
    );
  end

  // Output stage: hue wrap and scale, saturation clip.
  rgbhsv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_c[NumCells]),
    .stall_o      (stall_c[NumCells]),
    .item_i       (item_c[NumCells]),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o),
    .chroma_o     (chroma_o)
  );

endmodule

>>> design/rgbhsv_checker.sv
module rgbhsv_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rgbhsv_pkg::PixW-1:0] hue_o,
  input logic [rgbhsv_pkg::PixW-1:0] saturation_o,
  input logic [rgbhsv_pkg::PixW-1:0] value_o,
  input logic [rgbhsv_pkg::PixW-1:0] chroma_o
);
  import rgbhsv_pkg::*;

  // A stalled result stays put until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hue_o) &&
      $stable(saturation_o) && $stable(value_o) && $stable(chroma_o))
    else $error("stalled result changed");

  // Chroma never exceeds the largest channel.
  a_chroma_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chroma_o <= value_o)
    else $error("chroma above value");

  // Grey pixels carry no hue and no saturation.
  a_grey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chroma_o == '0 |-> hue_o == '0 && saturation_o == '0)
    else $error("grey pixel with hue or saturation");

  // Saturation is nonzero only for a colored, nonblack pixel.
  a_sat_needs_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturation_o != '0 |-> value_o != '0 && chroma_o != '0)
    else $error("saturation without value");

endmodule

bind rgb_to_hsv_chroma rgbhsv_checker u_rgbhsv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .value_o      (value_o),
  .chroma_o     (chroma_o)
);

>>> sim/rgb_to_hsv_chroma_tb.sv
module rgb_to_hsv_chroma_tb;
  import rgbhsv_pkg::*;

  localparam logic [PaddrW-1:0] ThrAddr      = 3'd0;
  localparam logic [PaddrW-1:0] UnmappedAddr = 3'd4;
  localparam logic [PixW-1:0]   ThrReset     = 8'd50;
  localparam int unsigned       DrainCycles  = 20;
  localparam int unsigned       CycleLimit   = 400000;

  // One converted pixel as the block presents it.
  typedef struct packed {
    logic [PixW-1:0] hue;
    logic [PixW-1:0] saturation;
    logic [PixW-1:0] value;
    logic [PixW-1:0] chroma;
  } hsv_t;

  // Holds the expected conversions in pixel order and compares each output transfer.
  class hsv_scoreboard;
    hsv_t expected_q[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Integer HSV conversion of one pixel under the given saturation threshold.
    function hsv_t convert(logic [PixW-1:0] r, logic [PixW-1:0] g, logic [PixW-1:0] b,
                           logic [PixW-1:0] thr);
      int      vmax;
      int      vmin;
      int      delta;
      int      diff;
      int      base;
      int      hue;
      int      sat;
      sector_e sector;
      hsv_t    res;
      vmax = (r > g) ? r : g;
      vmax = (vmax > b) ? vmax : b;
      vmin = (r < g) ? r : g;
      vmin = (vmin < b) ? vmin : b;
      delta = vmax - vmin;
      res = '0;
      res.value = vmax[PixW-1:0];
      // A grey or black pixel has no hue, saturation or chroma.
      if (vmax != 0 && delta != 0) begin
        if (vmax > int'(thr)) begin
          sat = (delta * 256) / vmax;
          res.saturation = (sat > 255) ? 8'd255 : sat[PixW-1:0];
        end
        // Ties go to the first of red, green, blue.
        if (int'(r) == vmax) sector = SECTOR_RED;
        else if (int'(g) == vmax) sector = SECTOR_GREEN;
        else sector = SECTOR_BLUE;
        case (sector)
          SECTOR_RED: begin
            diff = int'(g) - int'(b);
            base = 0;
          end
          SECTOR_GREEN: begin
            diff = int'(b) - int'(r);
            base = 512;
          end
          default: begin
            diff = int'(r) - int'(g);
            base = 1024;
          end
        endcase
        // Signed division truncates toward zero, as the block's hue does.
        hue = base + (diff * 256) / delta;
        if (hue < 0) hue += 1536;
        hue = hue / 6;
        res.hue = hue[PixW-1:0];
        res.chroma = delta[PixW-1:0];
      end
      return res;
    endfunction

    function void note_pixel(logic [PixW-1:0] r, logic [PixW-1:0] g, logic [PixW-1:0] b,
                             logic [PixW-1:0] thr);
      expected_q.push_back(convert(r, g, b, thr));
    endfunction

    function void check_result(hsv_t got);
      hsv_t want;
      if (expected_q.size() == 0) begin
        $error("output transfer with no pixel pending: hue %0d sat %0d value %0d chroma %0d",
               got.hue, got.saturation, got.value, got.chroma);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, got.hue);
        mismatches++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
        mismatches++;
      end
      if (got.value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, got.value);
        mismatches++;
      end
      if (got.chroma !== want.chroma) begin
        $error("chroma: expected %0d, got %0d", want.chroma, got.chroma);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [PixW-1:0]   red_i;
  logic [PixW-1:0]   green_i;
  logic [PixW-1:0]   blue_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [PixW-1:0]   hue_o;
  logic [PixW-1:0]   saturation_o;
  logic [PixW-1:0]   value_o;
  logic [PixW-1:0]   chroma_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  hsv_scoreboard   board;
  logic [PixW-1:0] sat_thr;
  logic            quiet;
  int              reg_errors;
  int unsigned     cycle_count;

  // Corner pixels: extremes, ties between sectors, grey, full saturation,
  // negative red-sector hue and values around the reset threshold.
  logic [23:0] corner_px [22] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010000, 24'hFF0001, 24'hFF0100,
    24'h0001FF, 24'h0100FF, 24'h0A141E, 24'h330000, 24'h320000, 24'hFEFF00,
    24'hAA5555, 24'h55AAFF, 24'h7F80FF, 24'h01FEFD
  };

  rgb_to_hsv_chroma i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .value_o     (value_o),
    .chroma_o    (chroma_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every output transfer is checked against the oldest pending pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(hsv_t'({hue_o, saturation_o, value_o, chroma_o}));
    end
  end

  // Output back-pressure: random stall bursts between runs of free flow.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat (($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 25)) @(posedge clk_i);
      if (!quiet) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // One register access: setup cycle, access cycle until pready, then the bus goes idle.
  task automatic apb_access(input logic is_write, input logic [PaddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_threshold();
    logic [31:0] rdata;
    apb_access(1'b0, ThrAddr, 32'd0, rdata);
    if (rdata !== {24'd0, sat_thr}) begin
      $error("sat_value_threshold: expected %0d, got %0d", sat_thr, rdata);
      reg_errors++;
    end
  endtask

  // Let the pipeline empty before touching the register.
  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Write the threshold with random upper bits, which the block must drop.
  task automatic set_threshold(input logic [PixW-1:0] thr);
    logic [31:0] rdata;
    wait_drained();
    apb_access(1'b1, ThrAddr, {24'($urandom_range(0, 24'hFFFFFF)), thr}, rdata);
    sat_thr = thr;
    check_threshold();
  endtask

  // Present one pixel, hold it until the transfer, then maybe leave a gap.
  task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] b);
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel(r, g, b, sat_thr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // Random pixels weighted toward full saturation, ties and near-grey colors.
  function automatic logic [23:0] random_pixel();
    logic [PixW-1:0] c [3];
    int              pick;
    int              top;
    for (int i = 0; i < 3; i++) c[i] = PixW'($urandom_range(0, 255));
    pick = $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      5, 6: c[pick] = 8'd0;
      7: c[(pick + 1) % 3] = c[pick];
      8: begin
        top = $urandom_range(0, 255);
        for (int i = 0; i < 3; i++) begin
          c[i] = PixW'(top - int'($urandom_range(0, (top < 3) ? top : 3)));
        end
      end
      9: begin
        c[1] = c[0];
        c[2] = c[0];
      end
      default: ;
    endcase
    return {c[0], c[1], c[2]};
  endfunction

  task automatic run_pixels(input int unsigned count);
    logic [23:0] px;
    foreach (corner_px[i]) send_pixel(corner_px[i][23:16], corner_px[i][15:8],
                                      corner_px[i][7:0]);
    repeat (count) begin
      px = random_pixel();
      send_pixel(px[23:16], px[15:8], px[7:0]);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] rdata;
    board       = new();
    cycle_count = 0;
    reg_errors  = 0;
    quiet       = 1'b0;
    sat_thr     = ThrReset;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    red_i       = '0;
    green_i     = '0;
    blue_i      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset threshold first, then the extremes and a few random levels.
    check_threshold();
    run_pixels(270);
    set_threshold(8'd0);
    run_pixels(250);
    set_threshold(8'd255);
    run_pixels(250);

    // A write outside the register map must leave the threshold alone.
    wait_drained();
    apb_access(1'b1, UnmappedAddr, $urandom(), rdata);
    check_threshold();

    set_threshold(PixW'($urandom_range(1, 254)));
    run_pixels(250);
    set_threshold(PixW'($urandom_range(1, 254)));
    run_pixels(250);

    // Last stretch at full rate with no idling on either side.
    set_threshold(ThrReset);
    quiet = 1'b1;
    run_pixels(300);

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0 && reg_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rgbhsv_pkg.sv
design/rgbhsv_front.sv
design/rgbhsv_div_cell.sv
design/rgbhsv_back.sv
design/rgb_to_hsv_chroma.sv
design/rgbhsv_checker.sv
sim/rgb_to_hsv_chroma_tb.sv
